### src/wqj_pkg.sv
`default_nettype none
package wqj_pkg;

    localparam int TABLE_DEPTH  = 128;
    localparam int POS_W        = 7;
    localparam int COR_W        = 20;
    localparam int TRIG_W       = 16;
    localparam int CORDIC_STEPS = 16;
    localparam int PADDR_W      = 3;
    localparam int PDATA_W      = 32;
    localparam int WEIGHT_W     = 16;

    localparam logic [PADDR_W-1:0]        ADDR_JITTER_WEIGHT = 3'd0;
    localparam logic signed [WEIGHT_W-1:0] WEIGHT_RESET      = 16'sd4096;

    localparam logic signed [COR_W-1:0] CORDIC_START = 20'sd39797;
    localparam logic signed [COR_W-1:0] PI_Q16       = 20'sd205887;
    localparam logic signed [COR_W-1:0] HALF_PI_Q16  = 20'sd102944;
    localparam logic signed [12:0]      ROM_CENTRE   = 13'sd2048;

    localparam logic [11:0] ROM_Q12 [TABLE_DEPTH] = '{
        12'd1153, 12'd3264, 12'd304,  12'd1976, 12'd4066, 12'd2905, 12'd4049, 12'd2927,
        12'd2634, 12'd2944, 12'd3793, 12'd3467, 12'd12,   12'd565,  12'd728,  12'd1821,
        12'd2578, 12'd2512, 12'd2582, 12'd1277, 12'd349,  12'd1261, 12'd204,  12'd3169,
        12'd3149, 12'd3613, 12'd4001, 12'd1841, 12'd3349, 12'd2525, 12'd3106, 12'd3515,
        12'd4011, 12'd2692, 12'd1582, 12'd409,  12'd3941, 12'd445,  12'd4080, 12'd3857,
        12'd1664, 12'd651,  12'd2682, 12'd2204, 12'd1362, 12'd4007, 12'd4031, 12'd988,
        12'd2793, 12'd2676, 12'd248,  12'd232,  12'd3768, 12'd3710, 12'd2611, 12'd499,
        12'd3840, 12'd73,   12'd2527, 12'd2905, 12'd3519, 12'd3949, 12'd398,  12'd742,
        12'd1167, 12'd1693, 12'd1363, 12'd1397, 12'd3359, 12'd2296, 12'd752,  12'd1055,
        12'd1187, 12'd2141, 12'd3613, 12'd2681, 12'd2176, 12'd553,  12'd2463, 12'd1980,
        12'd1161, 12'd1863, 12'd2083, 12'd3678, 12'd3688, 12'd2819, 12'd2522, 12'd3206,
        12'd3797, 12'd1745, 12'd3039, 12'd333,  12'd4091, 12'd2258, 12'd280,  12'd1597,
        12'd637,  12'd1917, 12'd3883, 12'd828,  12'd1424, 12'd100,  12'd907,  12'd3468,
        12'd1604, 12'd2836, 12'd1001, 12'd74,   12'd1379, 12'd2881, 12'd3966, 12'd3656,
        12'd2205, 12'd3456, 12'd324,  12'd423,  12'd998,  12'd2845, 12'd3271, 12'd891,
        12'd3567, 12'd1509, 12'd936,  12'd1533, 12'd1423, 12'd3086, 12'd3649, 12'd685
    };

    localparam logic signed [COR_W-1:0] ATAN_Q16 [CORDIC_STEPS] = '{
        20'sd51472, 20'sd30385, 20'sd16055, 20'sd8150, 20'sd4091, 20'sd2047,
        20'sd1024,  20'sd512,   20'sd256,   20'sd128,  20'sd64,   20'sd32,
        20'sd16,    20'sd8,     20'sd4,     20'sd2
    };

    typedef struct packed {
        logic signed [COR_W-1:0] x;
        logic signed [COR_W-1:0] y;
        logic signed [COR_W-1:0] z;
        logic                    flip;
    } t_cor;

    typedef struct packed {
        logic signed [TRIG_W-1:0] c;
        logic signed [TRIG_W-1:0] s;
    } t_trig;

endpackage
`default_nettype wire

### src/wqj_if.sv
`default_nettype none
interface wqj_in_if #(parameter int CW = 16);
    logic                 valid;
    logic                 ready;
    logic signed [CW-1:0] in_w;
    logic signed [CW-1:0] in_x;
    logic signed [CW-1:0] in_y;
    logic signed [CW-1:0] in_z;
    logic [31:0]          seed_value;
    logic [31:0]          element_index;

    modport source (output valid, in_w, in_x, in_y, in_z, seed_value, element_index,
                    input ready);
    modport sink (input valid, in_w, in_x, in_y, in_z, seed_value, element_index,
                  output ready);
endinterface

interface wqj_out_if #(parameter int CW = 16);
    logic                 valid;
    logic                 ready;
    logic signed [CW-1:0] out_w;
    logic signed [CW-1:0] out_x;
    logic signed [CW-1:0] out_y;
    logic signed [CW-1:0] out_z;

    modport source (output valid, out_w, out_x, out_y, out_z, input ready);
    modport sink (input valid, out_w, out_x, out_y, out_z, output ready);
endinterface
`default_nettype wire

### src/wqj_angle.sv
`default_nettype none
module wqj_angle #(
    parameter int CW = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_en,
    input  wire logic                          i_valid,
    input  wire logic [wqj_pkg::WEIGHT_W-1:0]  i_weight,
    input  wire logic [31:0]                   i_seed,
    input  wire logic [31:0]                   i_index,
    input  wire logic [4*CW-1:0]               i_quat,
    output logic                               o_valid,
    output wqj_pkg::t_cor [2:0]                o_cor,
    output logic [4*CW-1:0]                    o_quat
);

    logic [wqj_pkg::POS_W-1:0] pos [3];
    logic signed [12:0]        cen [3];
    logic signed [28:0]        n_p [3];
    logic signed [28:0]        r_p [3];
    logic [4*CW-1:0]           r_q1;
    logic                      r_v1;
    logic signed [29:0]        h_full [3];
    logic signed [wqj_pkg::COR_W-1:0] h [3];
    wqj_pkg::t_cor [2:0]       n_cor;
    wqj_pkg::t_cor [2:0]       r_cor;
    logic [4*CW-1:0]           r_q2;
    logic                      r_v2;

    always_comb begin
        pos[0] = i_seed[6:0] + {i_index[5:0], 1'b0};
        pos[1] = i_seed[6:0] + i_index[6:0] + {i_index[5:0], 1'b0};
        pos[2] = i_seed[6:0] + i_index[6:0] + {i_index[4:0], 2'b00};
        for (int k = 0; k < 3; k++) begin
            cen[k] = $signed({1'b0, wqj_pkg::ROM_Q12[pos[k]]}) - wqj_pkg::ROM_CENTRE;
            n_p[k] = $signed(i_weight) * cen[k];
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            h_full[k] = ($signed({r_p[k][28], r_p[k]}) + 30'sd256) >>> 9;
            h[k] = h_full[k][wqj_pkg::COR_W-1:0];
            n_cor[k].x = wqj_pkg::CORDIC_START;
            n_cor[k].y = '0;
            if (h[k] > wqj_pkg::HALF_PI_Q16) begin
                n_cor[k].z    = h[k] - wqj_pkg::PI_Q16;
                n_cor[k].flip = 1'b1;
            end else if (h[k] < -wqj_pkg::HALF_PI_Q16) begin
                n_cor[k].z    = h[k] + wqj_pkg::PI_Q16;
                n_cor[k].flip = 1'b1;
            end else begin
                n_cor[k].z    = h[k];
                n_cor[k].flip = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p   <= n_p;
            r_q1  <= i_quat;
            r_cor <= n_cor;
            r_q2  <= r_q1;
        end
    end

    assign o_valid = r_v2;
    assign o_cor   = r_cor;
    assign o_quat  = r_q2;

endmodule
`default_nettype wire

### src/wqj_cordic_stage.sv
`default_nettype none
module wqj_cordic_stage #(
    parameter int FIRST = 0,
    parameter int STEPS = 4,
    parameter int QBITS = 64
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_en,
    input  wire logic                i_valid,
    input  wire wqj_pkg::t_cor [2:0] i_cor,
    input  wire logic [QBITS-1:0]    i_quat,
    output logic                     o_valid,
    output wqj_pkg::t_cor [2:0]      o_cor,
    output logic [QBITS-1:0]         o_quat
);

    wqj_pkg::t_cor [2:0] n_cor;
    wqj_pkg::t_cor [2:0] r_cor;
    logic [QBITS-1:0]    r_quat;
    logic                r_v;

    always_comb begin
        logic signed [wqj_pkg::COR_W-1:0] dx;
        logic signed [wqj_pkg::COR_W-1:0] dy;
        n_cor = i_cor;
        for (int k = 0; k < 3; k++) begin
            for (int j = 0; j < STEPS; j++) begin
                dx = n_cor[k].y >>> (FIRST + j);
                dy = n_cor[k].x >>> (FIRST + j);
                if (n_cor[k].z >= 0) begin
                    n_cor[k].x = n_cor[k].x - dx;
                    n_cor[k].y = n_cor[k].y + dy;
                    n_cor[k].z = n_cor[k].z - wqj_pkg::ATAN_Q16[FIRST + j];
                end else begin
                    n_cor[k].x = n_cor[k].x + dx;
                    n_cor[k].y = n_cor[k].y - dy;
                    n_cor[k].z = n_cor[k].z + wqj_pkg::ATAN_Q16[FIRST + j];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_en) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cor  <= n_cor;
            r_quat <= i_quat;
        end
    end

    assign o_valid = r_v;
    assign o_cor   = r_cor;
    assign o_quat  = r_quat;

endmodule
`default_nettype wire

### src/wqj_rot.sv
`default_nettype none
module wqj_rot #(
    parameter int AXIS = 0,
    parameter int IW   = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_en,
    input  wire logic                     i_valid,
    input  wire wqj_pkg::t_trig [2:0]     i_trig,
    input  wire logic [3:0][IW-1:0]       i_quat,
    output logic                          o_valid,
    output wqj_pkg::t_trig [2:0]          o_trig,
    output logic [3:0][IW:0]              o_quat
);

    localparam int PW = IW + wqj_pkg::TRIG_W;
    localparam int SW = PW + 1;

    logic signed [PW-1:0] n_pc [4];
    logic signed [PW-1:0] n_ps [4];
    logic signed [PW-1:0] r_pc [4];
    logic signed [PW-1:0] r_ps [4];
    wqj_pkg::t_trig [2:0] r_trig1;
    wqj_pkg::t_trig [2:0] r_trig2;
    logic                 r_v1;
    logic                 r_v2;
    logic signed [SW-1:0] sum [4];
    logic [3:0][IW:0]     n_q;
    logic [3:0][IW:0]     r_q;

    always_comb begin
        for (int j = 0; j < 4; j++) begin
            n_pc[j] = $signed(i_quat[j]) * i_trig[AXIS].c;
            n_ps[j] = $signed(i_quat[j]) * i_trig[AXIS].s;
        end
    end

    always_comb begin
        logic signed [SW-1:0] rnd;
        if (AXIS == 0) begin
            sum[0] = SW'(r_pc[0]) - SW'(r_ps[1]);
            sum[1] = SW'(r_ps[0]) + SW'(r_pc[1]);
            sum[2] = SW'(r_pc[2]) + SW'(r_ps[3]);
            sum[3] = SW'(r_pc[3]) - SW'(r_ps[2]);
        end else if (AXIS == 1) begin
            sum[0] = SW'(r_pc[0]) - SW'(r_ps[2]);
            sum[1] = SW'(r_pc[1]) - SW'(r_ps[3]);
            sum[2] = SW'(r_ps[0]) + SW'(r_pc[2]);
            sum[3] = SW'(r_ps[1]) + SW'(r_pc[3]);
        end else begin
            sum[0] = SW'(r_pc[0]) - SW'(r_ps[3]);
            sum[1] = SW'(r_pc[1]) + SW'(r_ps[2]);
            sum[2] = SW'(r_pc[2]) - SW'(r_ps[1]);
            sum[3] = SW'(r_ps[0]) + SW'(r_pc[3]);
        end
        for (int j = 0; j < 4; j++) begin
            rnd    = (sum[j] + SW'(8192)) >>> 14;
            n_q[j] = rnd[IW:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pc    <= n_pc;
            r_ps    <= n_ps;
            r_trig1 <= i_trig;
            r_q     <= n_q;
            r_trig2 <= r_trig1;
        end
    end

    assign o_valid = r_v2;
    assign o_trig  = r_trig2;
    assign o_quat  = r_q;

endmodule
`default_nettype wire

### src/weighted_quaternion_jitter_core.sv
`default_nettype none
// Applies a small random rotation to each quaternion: three angles are drawn from a fixed
// 128-entry table at positions set by the seed and element index, scaled by jitter_weight,
// and the input is multiplied by the pitch, yaw and roll rotations, saturating to Q1.14.
// The pipeline accepts one transaction every cycle unless the output stalls; a stall there
// holds every stage. Stages: angle, sixteen CORDIC iterations done four to a stage, trig,
// two for each of the three quaternion products, and the output register.
module weighted_quaternion_jitter_core #(
    parameter int COMPONENT_WIDTH = 16
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    wqj_in_if.sink                              i_in,
    wqj_out_if.source                           o_out,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [wqj_pkg::PADDR_W-1:0]    paddr,
    input  wire logic [wqj_pkg::PDATA_W-1:0]    pwdata,
    output logic [wqj_pkg::PDATA_W-1:0]         prdata,
    output logic                                pready
);

    localparam int CW = COMPONENT_WIDTH;
    localparam int FW = CW + 3;

    logic                                weight_wr;
    logic [wqj_pkg::WEIGHT_W-1:0]        r_jitter_weight;
    logic                                en;
    logic                                a_valid;
    wqj_pkg::t_cor [2:0]                 a_cor;
    logic [4*CW-1:0]                     a_quat;
    logic                                c_valid [5];
    wqj_pkg::t_cor [2:0]                 c_cor [5];
    logic [4*CW-1:0]                     c_quat [5];
    wqj_pkg::t_trig [2:0]                n_trig;
    wqj_pkg::t_trig [2:0]                r_trig;
    logic [3:0][CW-1:0]                  r_tq;
    logic                                r_tv;
    logic                                v1, v2, v3;
    wqj_pkg::t_trig [2:0]                t1, t2, t3;
    logic [3:0][CW:0]                    q1;
    logic [3:0][CW+1:0]                  q2;
    logic [3:0][CW+2:0]                  q3;
    logic [3:0][CW-1:0]                  n_out;
    logic [3:0][CW-1:0]                  r_out;
    logic                                r_ov;

    assign weight_wr = psel && penable && pwrite && (paddr == wqj_pkg::ADDR_JITTER_WEIGHT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_jitter_weight <= wqj_pkg::WEIGHT_RESET;
        end else if (weight_wr) begin
            r_jitter_weight <= pwdata[wqj_pkg::WEIGHT_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr == wqj_pkg::ADDR_JITTER_WEIGHT) begin
            prdata = {{(wqj_pkg::PDATA_W - wqj_pkg::WEIGHT_W){1'b0}}, r_jitter_weight};
        end
    end
    assign pready = 1'b1;

    assign en         = !r_ov || o_out.ready;
    assign i_in.ready = en;

    wqj_angle #(.CW(CW)) u_angle (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (i_in.valid),
        .i_weight (r_jitter_weight),
        .i_seed   (i_in.seed_value),
        .i_index  (i_in.element_index),
        .i_quat   ({i_in.in_z, i_in.in_y, i_in.in_x, i_in.in_w}),
        .o_valid  (a_valid),
        .o_cor    (a_cor),
        .o_quat   (a_quat)
    );

    assign c_valid[0] = a_valid;
    assign c_cor[0]   = a_cor;
    assign c_quat[0]  = a_quat;

    for (genvar g = 0; g < 4; g++) begin : g_cordic
        wqj_cordic_stage #(.FIRST(4 * g), .STEPS(4), .QBITS(4 * CW)) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (c_valid[g]),
            .i_cor   (c_cor[g]),
            .i_quat  (c_quat[g]),
            .o_valid (c_valid[g+1]),
            .o_cor   (c_cor[g+1]),
            .o_quat  (c_quat[g+1])
        );
    end

    always_comb begin
        logic signed [wqj_pkg::COR_W-1:0] cr;
        logic signed [wqj_pkg::COR_W-1:0] sr;
        for (int k = 0; k < 3; k++) begin
            cr = (c_cor[4][k].x + 20'sd2) >>> 2;
            sr = (c_cor[4][k].y + 20'sd2) >>> 2;
            if (c_cor[4][k].flip) begin
                cr = -cr;
                sr = -sr;
            end
            n_trig[k].c = cr[wqj_pkg::TRIG_W-1:0];
            n_trig[k].s = sr[wqj_pkg::TRIG_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tv <= 1'b0;
        end else if (en) begin
            r_tv <= c_valid[4];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_trig <= n_trig;
            r_tq   <= c_quat[4];
        end
    end

    wqj_rot #(.AXIS(0), .IW(CW)) u_pitch (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (en), .i_valid (r_tv),
        .i_trig (r_trig), .i_quat (r_tq), .o_valid (v1), .o_trig (t1), .o_quat (q1)
    );

    wqj_rot #(.AXIS(1), .IW(CW + 1)) u_yaw (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (en), .i_valid (v1),
        .i_trig (t1), .i_quat (q1), .o_valid (v2), .o_trig (t2), .o_quat (q2)
    );

    wqj_rot #(.AXIS(2), .IW(CW + 2)) u_roll (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (en), .i_valid (v2),
        .i_trig (t2), .i_quat (q2), .o_valid (v3), .o_trig (t3), .o_quat (q3)
    );

    always_comb begin
        for (int j = 0; j < 4; j++) begin
            if ((&q3[j][FW-1:CW-1]) || !(|q3[j][FW-1:CW-1])) begin
                n_out[j] = q3[j][CW-1:0];
            end else if (q3[j][FW-1]) begin
                n_out[j] = {1'b1, {(CW-1){1'b0}}};
            end else begin
                n_out[j] = {1'b0, {(CW-1){1'b1}}};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en) begin
            r_ov <= v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid = r_ov;
    assign o_out.out_w = r_out[0];
    assign o_out.out_x = r_out[1];
    assign o_out.out_y = r_out[2];
    assign o_out.out_z = r_out[3];

endmodule
`default_nettype wire

### test/tb.sv
module tb;

    localparam int CW = 16;
    localparam int LATENCY = 14;
    localparam int N_RANDOM = 1750;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic signed [CW-1:0] w;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
    } t_quat;

    class rotation_board;
        t_quat expected_q[$];
        logic signed [wqj_pkg::WEIGHT_W-1:0] weight;
        int errors;

        function new();
            weight = wqj_pkg::WEIGHT_RESET;
            errors = 0;
        endfunction

        function longint fshift(longint v, int s);
            return v >>> s;
        endfunction

        function void half_trig(longint h, output longint c, output longint s);
            longint x, y, z, dx, dy;
            bit flip;
            x = wqj_pkg::CORDIC_START;
            y = 0;
            z = h;
            flip = 0;
            if (z > wqj_pkg::HALF_PI_Q16) begin
                z -= wqj_pkg::PI_Q16;
                flip = 1;
            end else if (z < -wqj_pkg::HALF_PI_Q16) begin
                z += wqj_pkg::PI_Q16;
                flip = 1;
            end
            for (int i = 0; i < wqj_pkg::CORDIC_STEPS; i++) begin
                dx = fshift(y, i);
                dy = fshift(x, i);
                if (z >= 0) begin
                    x -= dx;
                    y += dy;
                    z -= wqj_pkg::ATAN_Q16[i];
                end else begin
                    x += dx;
                    y -= dy;
                    z += wqj_pkg::ATAN_Q16[i];
                end
            end
            x = fshift(x + 2, 2);
            y = fshift(y + 2, 2);
            c = flip ? -x : x;
            s = flip ? -y : y;
        endfunction

        function longint rq(longint v);
            return fshift(v + 8192, 14);
        endfunction

        function void product(ref longint a[4], input longint b[4]);
            longint r[4];
            r[0] = rq(a[0]*b[0] - a[1]*b[1] - a[2]*b[2] - a[3]*b[3]);
            r[1] = rq(a[0]*b[1] + a[1]*b[0] + a[2]*b[3] - a[3]*b[2]);
            r[2] = rq(a[0]*b[2] - a[1]*b[3] + a[2]*b[0] + a[3]*b[1]);
            r[3] = rq(a[0]*b[3] + a[1]*b[2] - a[2]*b[1] + a[3]*b[0]);
            a = r;
        endfunction

        function longint sat(longint v);
            if (v > 32767) return 32767;
            if (v < -32768) return -32768;
            return v;
        endfunction

        function void note_input(t_quat q, logic [31:0] seed, logic [31:0] idx);
            longint a[4], b[4], h, c, s, ctr;
            logic [31:0] pos;
            t_quat r;
            int mul[3] = '{2, 3, 5};
            a = '{q.w, q.x, q.y, q.z};
            for (int ax = 0; ax < 3; ax++) begin
                pos = seed + idx * mul[ax];
                ctr = longint'(wqj_pkg::ROM_Q12[pos[6:0]]) - 2048;
                h = fshift(longint'(weight) * ctr + 256, 9);
                half_trig(h, c, s);
                b = '{c, 0, 0, 0};
                b[ax + 1] = s;
                product(a, b);
            end
            r.w = CW'(sat(a[0]));
            r.x = CW'(sat(a[1]));
            r.y = CW'(sat(a[2]));
            r.z = CW'(sat(a[3]));
            expected_q.push_back(r);
        endfunction

        function void check_result(t_quat got);
            t_quat e;
            if (expected_q.size() == 0) begin
                $error("result with nothing expected");
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (got.w !== e.w) begin
                $error("out_w expected %0d got %0d", e.w, got.w);
                errors++;
            end
            if (got.x !== e.x) begin
                $error("out_x expected %0d got %0d", e.x, got.x);
                errors++;
            end
            if (got.y !== e.y) begin
                $error("out_y expected %0d got %0d", e.y, got.y);
                errors++;
            end
            if (got.z !== e.z) begin
                $error("out_z expected %0d got %0d", e.z, got.z);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [wqj_pkg::PADDR_W-1:0] paddr = '0;
    logic [wqj_pkg::PDATA_W-1:0] pwdata = '0;
    logic [wqj_pkg::PDATA_W-1:0] prdata;
    logic pready;
    int cycles = 0;
    int n_sent = 0, n_checked = 0;
    bit stall_on = 0;
    rotation_board board = new();

    wqj_in_if #(CW) in_ch();
    wqj_out_if #(CW) out_ch();

    weighted_quaternion_jitter_core #(.COMPONENT_WIDTH(CW)) u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch.sink), .o_out(out_ch.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        in_ch.valid = 0;
        in_ch.in_w = 0;
        in_ch.in_x = 0;
        in_ch.in_y = 0;
        in_ch.in_z = 0;
        in_ch.seed_value = 0;
        in_ch.element_index = 0;
        out_ch.ready = 0;
    end

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb failed");
            $finish;
        end
    end

    // The receiver stalls in runs, with quiet periods where it never stalls.
    always @(posedge i_clk) begin
        if (out_ch.valid && out_ch.ready) begin
            board.check_result({out_ch.out_w, out_ch.out_x, out_ch.out_y, out_ch.out_z});
            n_checked <= n_checked + 1;
        end
        if ($urandom_range(0, 199) == 0) stall_on <= !stall_on;
        out_ch.ready <= i_rst_n && (!stall_on || $urandom_range(0, 2) != 0);
    end

    task automatic write_weight(logic signed [wqj_pkg::WEIGHT_W-1:0] w);
        @(posedge i_clk);
        psel <= 1;
        pwrite <= 1;
        penable <= 0;
        paddr <= wqj_pkg::ADDR_JITTER_WEIGHT;
        pwdata <= {{(wqj_pkg::PDATA_W-wqj_pkg::WEIGHT_W){w[wqj_pkg::WEIGHT_W-1]}}, w};
        @(posedge i_clk);
        penable <= 1;
        do @(posedge i_clk); while (!pready);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        board.weight = w;
    endtask

    task automatic send(t_quat q, logic [31:0] seed, logic [31:0] idx);
        in_ch.valid <= 1;
        in_ch.in_w <= q.w;
        in_ch.in_x <= q.x;
        in_ch.in_y <= q.y;
        in_ch.in_z <= q.z;
        in_ch.seed_value <= seed;
        in_ch.element_index <= idx;
        do @(posedge i_clk); while (!in_ch.ready);
        board.note_input(q, seed, idx);
        n_sent++;
    endtask

    task automatic pause_sender();
        in_ch.valid <= 0;
        repeat ($urandom_range(1, 6)) @(posedge i_clk);
    endtask

    task automatic drain();
        in_ch.valid <= 0;
        while (board.expected_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    function automatic t_quat rand_quat(bit extremes);
        t_quat q;
        q = {$urandom, $urandom};
        if (extremes) begin
            q.w = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            q.x = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
        end else if ($urandom_range(0, 3) != 0) begin
            q.w = CW'(int'($urandom_range(0, 32767)) - 16384);
            q.x = CW'(int'($urandom_range(0, 32767)) - 16384);
            q.y = CW'(int'($urandom_range(0, 16383)) - 8192);
            q.z = CW'(int'($urandom_range(0, 16383)) - 8192);
        end
        return q;
    endfunction

    initial begin
        logic signed [wqj_pkg::WEIGHT_W-1:0] weights[6];
        int burst;
        weights = '{16'sh7fff, 16'sh8000, 16'sd0, 16'sd1, -16'sd1, 16'sd4096};
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: reset weight, extreme components, wrapping seed and index.
        send('{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff}, 0, 0);
        send('{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000}, 32'hffff_ffff, 32'hffff_ffff);
        send('{16'sd16384, 0, 0, 0}, 32'h8000_0000, 32'h8000_0001);
        send('{0, 16'sd16384, 0, 0}, 5, 17);
        send('{16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000}, 127, 128);
        drain();
        foreach (weights[k]) begin
            write_weight(weights[k]);
            for (int j = 0; j < 4; j++)
                send(rand_quat(1), $urandom, $urandom);
            send('{16'sd16384, 0, 0, 0}, k * 19, k);
            drain();
        end

        for (int ph = 0; ph < 5; ph++) begin
            write_weight(ph == 4 ? wqj_pkg::WEIGHT_RESET : 16'($urandom));
            for (int i = 0; i < N_RANDOM / 5; ) begin
                burst = $urandom_range(1, 30);
                for (int j = 0; j < burst; j++, i++)
                    send(rand_quat($urandom_range(0, 15) == 0), $urandom, $urandom);
                if ($urandom_range(0, 2) != 0) pause_sender();
            end
            drain();
        end

        $display("Sent %0d quaternions over twelve weight phases, extremes included;",
                 n_sent);
        $display("checked %0d rotated results under random output stalls.", n_checked);
        if (board.errors == 0 && board.expected_q.size() == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end
endmodule
